// ----- hdl/raw_linearize_bilinear_demosaic_top_macros.svh -----
// Assertion macros shared by the demosaic checker.
// Depends on nothing; the including module supplies clk_i and rst_ni.
`ifndef RAW_LINEARIZE_BILINEAR_DEMOSAIC_TOP_MACROS_SVH
`define RAW_LINEARIZE_BILINEAR_DEMOSAIC_TOP_MACROS_SVH

// Checked on every rising edge outside reset.
`define RLBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define RLBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hdl/rlbd_pkg.sv -----
// Package for the raw linearize and bilinear demosaic block.
// Holds the sequencer states, register indexes and fixed-point constants.
package rlbd_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPD,
    ST_EMIT1,
    ST_HOLD1,
    ST_SHIFT,
    ST_EMIT2,
    ST_HOLD2
  } rlbd_state_e;

  localparam logic [2:0] REG_BLACK0  = 3'd0;
  localparam logic [2:0] REG_BLACK1  = 3'd1;
  localparam logic [2:0] REG_BLACK2  = 3'd2;
  localparam logic [2:0] REG_BLACK3  = 3'd3;
  localparam logic [2:0] REG_WHITE   = 3'd4;
  localparam logic [2:0] REG_PATTERN = 3'd5;
  localparam logic [2:0] REG_WIDTH   = 3'd6;
  localparam logic [2:0] REG_HEIGHT  = 3'd7;

  localparam logic [15:0] FULL_SCALE = 16'hFFFF;
  // ceil(2^22 / 5): exact floor division by five for sums below 2^19.
  localparam logic [19:0] RECIP5     = 20'd838861;
  localparam int          RECIP5_SH  = 22;

endpackage

// ----- hdl/rlbd_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module rlbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hdl/raw_linearize_bilinear_demosaic_top.sv -----
// Top level of the raw linearize and bilinear demosaic block.
// Uses rlbd_pkg and two rlbd_ram line memories.
//
// Usage:
//   Raw Bayer samples enter in raster order on the input channel (valid/stall),
//   one beat per pixel. Each pixel is linearized to Q0.16 and stored in two
//   line memories and a 3x3 window; RGB beats leave on the output channel.
//   Output runs one row and one column behind: the last column of a row gives
//   two beats, row 0 gives none. After the last row, frame_width beats with
//   flush set drain the final row; the last of them carries frame_end.
//   A flush beat before the drain row is taken and dropped.
//   Throughput: one item at a time; no new beat is taken until the last one
//   is done. A pixel beat passes the update, emit and hold states; one that
//   gives no result passes update only, and a dropped flush leaves the
//   sequencer idle. A division by the white-black span comes first (one
//   quotient bit per cycle); a row end adds shift, emit and hold states for
//   its second result. When the receiver stalls, the result is held and no
//   new beat is taken.
//   Reset sets config, state and position registers to defaults, window to zero;
//   line memories need no clearing, since only written rows are read.
module raw_linearize_bilinear_demosaic_top
  import rlbd_pkg::*;
#(
  parameter int MAX_WIDTH   = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] raw_sample_i,
  input  logic        flush_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] red_o,
  output logic [15:0] green_o,
  output logic [15:0] blue_o,
  output logic        frame_end_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;

  // Configuration.
  logic [15:0] black_q [4];
  logic [15:0] white_q;
  logic        bggr_q;
  logic [12:0] fwidth_q;
  logic [14:0] fheight_q;

  // Control.
  rlbd_state_e state_q, state_d;
  logic [CW-1:0] col_q, cur_col_q;
  logic [14:0]   row_q, cur_row_q;
  logic          drain_q, last_q;
  logic [3:0]    div_cnt_q;
  logic [16:0]   rem_q;
  logic [15:0]   low_q;
  logic [15:0]   div_d_q;
  logic [15:0]   nv_q;
  logic [15:0]   win_q [3][3];

  logic          accept, in_take, ram_we;
  logic [WW-1:0] w_eff;
  logic [14:0]   h_eff;
  logic          drain, last_col;
  logic [15:0]   samp, blk, a_val, d_val;
  logic [31:0]   numer;
  logic [16:0]   div_t;
  logic [15:0]   top_rd, mid_rd, top_v, mid_v;
  logic          emit1, emit2;

  logic [17:0]   corners;
  logic [16:0]   hor, ver;
  logic [18:0]   g5_sum;
  logic [38:0]   g5_prod;
  logic [15:0]   r_c, g_c, b_c;
  logic [1:0]    par;

  always_comb begin
    if (fwidth_q < 13'd2) begin
      w_eff = WW'(2);
    end else if (32'(fwidth_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(32'(fwidth_q));
    end
    h_eff = (fheight_q < 15'd2) ? 15'd2 : fheight_q;
  end

  assign accept   = in_valid_i && !in_stall_o;
  assign drain    = row_q >= h_eff;
  assign in_take  = accept && !(flush_i && !drain);
  assign last_col = (32'(col_q) + 32'd1) >= 32'(w_eff);

  assign samp  = 16'(raw_sample_i[SAMPLE_BITS-1:0]);
  assign blk   = black_q[{row_q[0], col_q[0]}];
  assign a_val = samp - blk;
  assign d_val = white_q - blk;
  assign numer = {a_val, 16'h0000} - {16'h0000, a_val};
  assign div_t = {rem_q[15:0], low_q[15]};

  assign emit1 = (cur_row_q != 15'd0) && (cur_col_q != '0);
  assign emit2 = last_q && (cur_row_q != 15'd0);

  rlbd_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_line_above (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cur_col_q),
    .wdata_i(nv_q),
    .re_i   (in_take),
    .raddr_i(col_q),
    .rdata_o(mid_rd)
  );

  rlbd_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_line_two_above (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cur_col_q),
    .wdata_i(mid_v),
    .re_i   (in_take),
    .raddr_i(col_q),
    .rdata_o(top_rd)
  );

  assign top_v = (cur_row_q >= 15'd2) ? top_rd : 16'h0000;
  assign mid_v = (cur_row_q >= 15'd1) ? mid_rd : 16'h0000;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          if (drain || samp <= blk || white_q <= blk || a_val >= d_val) begin
            state_d = ST_UPD;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_cnt_q == 4'd15) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (emit1) begin
          state_d = ST_EMIT1;
        end else if (emit2) begin
          state_d = ST_SHIFT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT1: state_d = ST_HOLD1;
      ST_HOLD1: begin
        if (!out_stall_i) begin
          state_d = emit2 ? ST_SHIFT : ST_IDLE;
        end
      end
      ST_SHIFT: state_d = ST_EMIT2;
      ST_EMIT2: state_d = ST_HOLD2;
      ST_HOLD2: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_HOLD1) || (state_q == ST_HOLD2);
    ram_we      = (state_q == ST_UPD);
  end

  // Color interpolation from the window; the center sits at win_q[1][1].
  always_comb begin
    corners = 18'(win_q[0][0]) + 18'(win_q[0][2]) + 18'(win_q[2][0]) + 18'(win_q[2][2]);
    hor     = 17'(win_q[1][0]) + 17'(win_q[1][2]);
    ver     = 17'(win_q[0][1]) + 17'(win_q[2][1]);
    g5_sum  = 19'(win_q[1][1]) + 19'(corners);
    g5_prod = 39'(g5_sum) * 39'(RECIP5);
    if (state_q == ST_EMIT2) begin
      par = {~cur_row_q[0], cur_col_q[0]};
    end else begin
      par = {~cur_row_q[0], ~cur_col_q[0]};
    end
    unique case (par)
      2'd0: begin
        r_c = win_q[1][1];
        g_c = 16'((18'(hor) + 18'(ver)) >> 2);
        b_c = 16'(corners >> 2);
      end
      2'd1: begin
        r_c = 16'(hor >> 1);
        g_c = 16'(g5_prod >> RECIP5_SH);
        b_c = 16'(ver >> 1);
      end
      2'd2: begin
        r_c = 16'(ver >> 1);
        g_c = 16'(g5_prod >> RECIP5_SH);
        b_c = 16'(hor >> 1);
      end
      default: begin
        r_c = 16'(corners >> 2);
        g_c = 16'((18'(hor) + 18'(ver)) >> 2);
        b_c = win_q[1][1];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      black_q   <= '{default: 16'h0000};
      white_q   <= FULL_SCALE;
      bggr_q    <= 1'b0;
      fwidth_q  <= 13'd4096;
      fheight_q <= 15'd4096;
      state_q   <= ST_IDLE;
      col_q     <= '0;
      row_q     <= '0;
      cur_col_q <= '0;
      cur_row_q <= '0;
      drain_q   <= 1'b0;
      last_q    <= 1'b0;
      div_cnt_q <= '0;
      win_q     <= '{default: '{default: 16'h0000}};
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i) inside
          REG_BLACK0, REG_BLACK1, REG_BLACK2, REG_BLACK3: begin
            black_q[cfg_idx_i[1:0]] <= cfg_wdata_i;
          end
          REG_WHITE:   white_q   <= cfg_wdata_i;
          REG_PATTERN: bggr_q    <= cfg_wdata_i[0];
          REG_WIDTH:   fwidth_q  <= cfg_wdata_i[12:0];
          REG_HEIGHT:  fheight_q <= cfg_wdata_i[14:0];
          default: ;
        endcase
      end
      if (in_take) begin
        cur_col_q <= col_q;
        cur_row_q <= row_q;
        drain_q   <= drain;
        last_q    <= last_col;
        div_cnt_q <= '0;
        if (last_col) begin
          col_q <= '0;
          row_q <= drain ? 15'd0 : row_q + 15'd1;
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      if (state_q == ST_DIV) begin
        div_cnt_q <= div_cnt_q + 4'd1;
      end
      if (state_q == ST_UPD) begin
        for (int i = 0; i < 3; i++) begin
          win_q[i][0] <= (cur_col_q == '0) ? 16'h0000 : win_q[i][1];
          win_q[i][1] <= (cur_col_q == '0) ? 16'h0000 : win_q[i][2];
        end
        win_q[0][2] <= top_v;
        win_q[1][2] <= mid_v;
        win_q[2][2] <= nv_q;
      end
      if (state_q == ST_SHIFT) begin
        for (int i = 0; i < 3; i++) begin
          win_q[i][0] <= win_q[i][1];
          win_q[i][1] <= win_q[i][2];
          win_q[i][2] <= 16'h0000;
        end
      end
    end
  end

  // Divider and result payload.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      div_d_q <= d_val;
      rem_q   <= {1'b0, numer[31:16]};
      low_q   <= numer[15:0];
      if (drain || samp <= blk || white_q <= blk) begin
        nv_q <= 16'h0000;
      end else if (a_val >= d_val) begin
        nv_q <= FULL_SCALE;
      end
    end
    if (state_q == ST_DIV) begin
      // Restoring division, one quotient bit per cycle into the low half.
      if (div_t >= {1'b0, div_d_q}) begin
        rem_q <= div_t - {1'b0, div_d_q};
        low_q <= {low_q[14:0], 1'b1};
        if (div_cnt_q == 4'd15) begin
          nv_q <= {low_q[14:0], 1'b1};
        end
      end else begin
        rem_q <= div_t;
        low_q <= {low_q[14:0], 1'b0};
        if (div_cnt_q == 4'd15) begin
          nv_q <= {low_q[14:0], 1'b0};
        end
      end
    end
    if (state_q == ST_EMIT1 || state_q == ST_EMIT2) begin
      red_o       <= bggr_q ? b_c : r_c;
      green_o     <= g_c;
      blue_o      <= bggr_q ? r_c : b_c;
      frame_end_o <= (state_q == ST_EMIT2) && drain_q;
    end
  end

endmodule

// ----- hdl/rlbd_checker.sv -----
// Port-level checker for the demosaic top level, bound to every instance.
// Depends on raw_linearize_bilinear_demosaic_top_macros.svh.
`include "raw_linearize_bilinear_demosaic_top_macros.svh"

module rlbd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] red_o,
  input logic [15:0] green_o,
  input logic [15:0] blue_o,
  input logic        frame_end_o
);

  `RLBD_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result beat dropped while stalled")
  `RLBD_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(red_o) && $stable(green_o) && $stable(blue_o) && $stable(frame_end_o), "stalled result changed")
  `RLBD_ASSERT_ALWAYS(a_one_side, !(out_valid_o && !in_stall_o), "input open while a result is pending")
  `RLBD_ASSERT(a_in_gap, in_valid_i && !in_stall_o |=> !out_valid_o, "result shown in the cycle after an input beat")
  `RLBD_ASSERT(a_out_gap, out_valid_o && !out_stall_i |=> !out_valid_o, "result beats without a gap")

endmodule

bind raw_linearize_bilinear_demosaic_top rlbd_checker u_rlbd_checker (.*);
